// ===== hdl/garch_variance_recursion_core_assert.svh =====
// assertion macros for the garch variance recursion core
// expects signals named clock and reset in the module that expands them
`ifndef GARCH_VARIANCE_RECURSION_CORE_ASSERT_SVH
`define GARCH_VARIANCE_RECURSION_CORE_ASSERT_SVH

// same-cycle implication
`define GVR_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GVR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/gvr_pkg.sv =====
// shared constants, register codes and structs of the garch variance core
// no dependencies
`timescale 1ns / 1ps

package gvr_pkg;

   localparam int ARCH_TAPS  = 2;
   localparam int GARCH_TAPS = 2;
   localparam int VAR_W      = 48;
   localparam int COEF_W     = 32;
   localparam int RES_W      = 32;
   localparam int ORD_W      = 2;
   localparam int DATA_W     = 64;
   localparam int NUM_REGS   = 8;
   localparam int IDX_W      = $clog2(NUM_REGS);
   localparam int ADDR_W     = IDX_W + 3;
   localparam int SQ_SHIFT   = 16;

   localparam int TAPS   = ARCH_TAPS + GARCH_TAPS;
   localparam int TAP_W  = $clog2(TAPS);
   localparam int OPS    = 2 * TAPS + 1;
   localparam int OP_W   = $clog2(OPS);
   localparam int PROD_W = 2 * COEF_W;
   localparam int ACC_W  = VAR_W + $clog2(TAPS + 1);

   localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

   typedef enum logic [IDX_W-1:0] {
      REG_OMEGA      = 3'd0,
      REG_ARCH_ONE   = 3'd1,
      REG_ARCH_TWO   = 3'd2,
      REG_GARCH_ONE  = 3'd3,
      REG_GARCH_TWO  = 3'd4,
      REG_ARCH_ORD   = 3'd5,
      REG_GARCH_ORD  = 3'd6,
      REG_INIT_VAR   = 3'd7
   } gvr_reg_type;

   typedef struct packed {
      logic [VAR_W-1:0]  omega;
      logic [COEF_W-1:0] arch_one;
      logic [COEF_W-1:0] arch_two;
      logic [COEF_W-1:0] garch_one;
      logic [COEF_W-1:0] garch_two;
      logic [ORD_W-1:0]  arch_order;
      logic [ORD_W-1:0]  garch_order;
      logic [VAR_W-1:0]  init_var;
   } gvr_cfg_type;

   // register values after reset
   localparam gvr_cfg_type CFG_RESET = '{
      omega:       VAR_W'(1),
      arch_one:    '0,
      arch_two:    '0,
      garch_one:   '0,
      garch_two:   '0,
      arch_order:  ORD_W'(1),
      garch_order: ORD_W'(1),
      init_var:    VAR_W'(1) << COEF_W
   };

   typedef struct packed {
      logic              en;
      logic [COEF_W-1:0] a;
      logic [COEF_W-1:0] b;
   } gvr_mul_req_type;

endpackage

// ===== hdl/gvr_if.sv =====
// request and response channel interfaces of the garch variance core
// depends on gvr_pkg
`timescale 1ns / 1ps

interface gvr_req_if import gvr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RES_W-1:0] residual;
   logic             start_series;

   modport source (output valid, residual, start_series, input ready);
   modport sink (input valid, residual, start_series, output ready);
endinterface

interface gvr_rsp_if import gvr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [VAR_W-1:0] variance;
   logic             saturated;

   modport source (output valid, variance, saturated, input ready);
   modport sink (input valid, variance, saturated, output ready);
endinterface

// ===== hdl/gvr_csr.sv =====
// apb-style configuration registers of the garch variance core
// depends on gvr_pkg
`timescale 1ns / 1ps

module gvr_csr import gvr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output gvr_cfg_type       cfg
);

   gvr_cfg_type cfg_ff, cfg_in;
   gvr_reg_type idx;
   logic        wr_en;

   assign pready = 1'b1;
   assign idx    = gvr_reg_type'(paddr[ADDR_W-1:3]);
   assign wr_en  = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_OMEGA:     cfg_in.omega       = pwdata[VAR_W-1:0];
            REG_ARCH_ONE:  cfg_in.arch_one    = pwdata[COEF_W-1:0];
            REG_ARCH_TWO:  cfg_in.arch_two    = pwdata[COEF_W-1:0];
            REG_GARCH_ONE: cfg_in.garch_one   = pwdata[COEF_W-1:0];
            REG_GARCH_TWO: cfg_in.garch_two   = pwdata[COEF_W-1:0];
            REG_ARCH_ORD:  cfg_in.arch_order  = pwdata[ORD_W-1:0];
            REG_GARCH_ORD: cfg_in.garch_order = pwdata[ORD_W-1:0];
            REG_INIT_VAR:  cfg_in.init_var    = pwdata[VAR_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_OMEGA:     prdata = DATA_W'(cfg_ff.omega);
         REG_ARCH_ONE:  prdata = DATA_W'(cfg_ff.arch_one);
         REG_ARCH_TWO:  prdata = DATA_W'(cfg_ff.arch_two);
         REG_GARCH_ONE: prdata = DATA_W'(cfg_ff.garch_one);
         REG_GARCH_TWO: prdata = DATA_W'(cfg_ff.garch_two);
         REG_ARCH_ORD:  prdata = DATA_W'(cfg_ff.arch_order);
         REG_GARCH_ORD: prdata = DATA_W'(cfg_ff.garch_order);
         REG_INIT_VAR:  prdata = DATA_W'(cfg_ff.init_var);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/gvr_mul.sv =====
// shared 32x32 unsigned multiplier with registered product
// depends on gvr_pkg
`timescale 1ns / 1ps

module gvr_mul import gvr_pkg::*; (
   input  logic              clock,
   input  gvr_mul_req_type   mul_req,
   output logic [PROD_W-1:0] prod
);

   logic [PROD_W-1:0] prod_ff;

   assign prod = prod_ff;

   always_ff @(posedge clock) begin
      if (mul_req.en) begin
         prod_ff <= PROD_W'(mul_req.a) * PROD_W'(mul_req.b);
      end
   end

endmodule

// ===== hdl/gvr_seq.sv =====
// sequencer, histories, accumulator and response register of the variance core
// depends on gvr_pkg, gvr_if and gvr_mul
`timescale 1ns / 1ps

module gvr_seq import gvr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  gvr_cfg_type cfg,
   gvr_req_if.sink     req,
   gvr_rsp_if.source   rsp
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_ISSUE  = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic              tag_valid_ff, tag_valid_in;
   logic              tag_hi_ff, tag_hi_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [RES_W-1:0]  mag_ff, mag_in;
   logic [VAR_W-1:0]  sqh_ff [ARCH_TAPS];
   logic [VAR_W-1:0]  sqh_in [ARCH_TAPS];
   logic [VAR_W-1:0]  vh_ff [GARCH_TAPS];
   logic [VAR_W-1:0]  vh_in [GARCH_TAPS];
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VAR_W-1:0]  rsp_var_ff, rsp_var_in;
   logic              rsp_sat_ff, rsp_sat_in;

   gvr_mul_req_type   mul_req;
   logic [PROD_W-1:0] prod;

   logic [ORD_W-1:0]  qa, qg;
   logic [VAR_W-1:0]  tap_x [TAPS];
   logic [COEF_W-1:0] tap_c [TAPS];
   logic [TAP_W-1:0]  tap;
   logic [VAR_W-1:0]  sel_x;
   logic [VAR_W-1:0]  h;
   logic              sat;
   logic              accept;
   logic              out_free;

   gvr_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (prod)
   );

   assign req.ready     = (state_ff == ST_IDLE);
   assign accept        = req.valid && req.ready;
   assign out_free      = !rsp_valid_ff || rsp.ready;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.variance  = rsp_var_ff;
   assign rsp.saturated = rsp_sat_ff;

   // orders above the tap limit act as the limit
   assign qa = (cfg.arch_order > ORD_W'(ARCH_TAPS)) ? ORD_W'(ARCH_TAPS) : cfg.arch_order;
   assign qg = (cfg.garch_order > ORD_W'(GARCH_TAPS)) ? ORD_W'(GARCH_TAPS) : cfg.garch_order;

   // tap operands: squared residual taps first, then variance taps
   always_comb begin
      for (int i = 0; i < ARCH_TAPS; i++) begin
         tap_x[i] = sqh_ff[i];
         if (ORD_W'(i) >= qa) tap_c[i] = '0;
         else if (i == 0)     tap_c[i] = cfg.arch_one;
         else if (i == 1)     tap_c[i] = cfg.arch_two;
         else                 tap_c[i] = '0;
      end
      for (int j = 0; j < GARCH_TAPS; j++) begin
         tap_x[ARCH_TAPS+j] = vh_ff[j];
         if (ORD_W'(j) >= qg) tap_c[ARCH_TAPS+j] = '0;
         else if (j == 0)     tap_c[ARCH_TAPS+j] = cfg.garch_one;
         else if (j == 1)     tap_c[ARCH_TAPS+j] = cfg.garch_two;
         else                 tap_c[ARCH_TAPS+j] = '0;
      end
   end

   assign tap   = op_ff[TAP_W:1];
   assign sel_x = tap_x[tap];

   // clamp and floor of the finished sum
   assign sat = |acc_ff[ACC_W-1:VAR_W];
   always_comb begin
      if (sat)                 h = VAR_MAX;
      else if (acc_ff == '0)   h = VAR_W'(1);
      else                     h = acc_ff[VAR_W-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      tag_valid_in = 1'b0;
      tag_hi_in    = tag_hi_ff;
      acc_in       = acc_ff;
      mag_in       = mag_ff;
      sqh_in       = sqh_ff;
      vh_in        = vh_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_var_in   = rsp_var_ff;
      rsp_sat_in   = rsp_sat_ff;
      mul_req      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               acc_in   = ACC_W'(cfg.omega);
               mag_in   = req.residual[RES_W-1] ? RES_W'(~req.residual + 1'b1)
                                                : req.residual;
               op_in    = '0;
               state_in = ST_ISSUE;
               if (req.start_series) begin
                  for (int i = 0; i < ARCH_TAPS; i++) sqh_in[i] = cfg.init_var;
                  for (int j = 0; j < GARCH_TAPS; j++) vh_in[j] = cfg.init_var;
               end
            end
         end
         ST_ISSUE: begin
            mul_req.en = 1'b1;
            if (op_ff == OP_W'(OPS - 1)) begin
               mul_req.a = mag_ff;
               mul_req.b = mag_ff;
               state_in  = ST_FINISH;
            end else if (op_ff[0]) begin
               mul_req.a = COEF_W'(sel_x[VAR_W-1:COEF_W]);
               mul_req.b = tap_c[tap];
            end else begin
               mul_req.a = sel_x[COEF_W-1:0];
               mul_req.b = tap_c[tap];
            end
            tag_valid_in = 1'b1;
            tag_hi_in    = op_ff[0];
            op_in        = OP_W'(op_ff + 1'b1);
            // fold in the partial product of the previous op
            if (tag_valid_ff) begin
               if (tag_hi_ff) acc_in = acc_ff + ACC_W'(prod[VAR_W-1:0]);
               else           acc_in = acc_ff + ACC_W'(prod[PROD_W-1:COEF_W]);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               for (int i = ARCH_TAPS - 1; i > 0; i--) sqh_in[i] = sqh_ff[i-1];
               sqh_in[0] = prod[SQ_SHIFT +: VAR_W];
               for (int j = GARCH_TAPS - 1; j > 0; j--) vh_in[j] = vh_ff[j-1];
               vh_in[0]     = h;
               rsp_valid_in = 1'b1;
               rsp_var_in   = h;
               rsp_sat_in   = sat;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= '0;
         tag_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ARCH_TAPS; i++) sqh_ff[i] <= '0;
         for (int j = 0; j < GARCH_TAPS; j++) vh_ff[j] <= '0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         tag_valid_ff <= tag_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         sqh_ff       <= sqh_in;
         vh_ff        <= vh_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_hi_ff  <= tag_hi_in;
      acc_ff     <= acc_in;
      mag_ff     <= mag_in;
      rsp_var_ff <= rsp_var_in;
      rsp_sat_ff <= rsp_sat_in;
   end

endmodule

// ===== hdl/garch_variance_recursion_core.sv =====
// top level of the garch(2,2) conditional variance core
// depends on gvr_pkg, gvr_if, gvr_csr, gvr_seq and the assertion macro header
`timescale 1ns / 1ps

`include "garch_variance_recursion_core_assert.svh"

// Computes h = omega + a1*e2[t-1] + a2*e2[t-2] + b1*h[t-1] + b2*h[t-2] in unsigned
// Q16.32 for each signed Q8.24 residual request, clamped to 2^48-1 (saturated set)
// and floored at 1 LSB, then shifts the squared residual and h into the histories;
// start_series reloads both histories with initial_variance first. One 32x32
// multiplier does all the work: eight partial products for the four taps plus the
// residual square, one per cycle; a request goes through accept, nine multiplies
// and a finish that waits while a previous response is not yet taken. Registers
// sit at byte address 8*i on the 64-bit apb port; the user must write them only
// while the core is idle, as the core itself does not enforce this.
module garch_variance_recursion_core import gvr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   gvr_req_if.sink           req,
   gvr_rsp_if.source         rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   gvr_cfg_type cfg;

   gvr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gvr_seq u_seq (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req),
      .rsp   (rsp)
   );

   `GVR_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready after accept")
   `GVR_ASSERT_SAME(a_floor, rsp.valid, rsp.variance != '0, "variance below floor")
   `GVR_ASSERT_SAME(a_sat_max, rsp.valid && rsp.saturated, rsp.variance == VAR_MAX, "sat not max")

endmodule
